FILE: sv/amc_pkg.sv
// ----------------------------------------------------------------------------
// amc_pkg: shared constants, types and the soft clip table builder.
// Holds buffer sizes, field widths, status codes and the clip curve.
// ----------------------------------------------------------------------------
package amc_pkg;

    localparam int MAX_SAMPLES        = 262144;
    localparam int FADE_LEN           = 44;
    localparam int CLIP_TABLE_ENTRIES = 1024;

    localparam int ADDR_W    = $clog2(MAX_SAMPLES);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int ROM_AW    = $clog2(CLIP_TABLE_ENTRIES + 1);
    localparam int FN_W      = $clog2(FADE_LEN + 1);
    localparam int AM19_W    = 31;
    localparam int NUM_W     = AM19_W + FN_W;
    localparam int DEN_W     = 16 + FN_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [15:0] LOWPASS_RESET = 16'd16253;
    localparam logic [14:0] OUT_GAIN      = 15'd19200;

    // Result status codes.
    localparam logic [2:0] ST_LOADED  = 3'd0;
    localparam logic [2:0] ST_EMITTED = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    // Input function codes.
    localparam logic [1:0] FN_LOAD    = 2'd0;
    localparam logic [1:0] FN_EMIT    = 2'd1;
    localparam logic [1:0] FN_RESTART = 2'd2;
    localparam logic [1:0] FN_UNUSED  = 2'd3;

    typedef logic [15:0] t_clip_rom [0:CLIP_TABLE_ENTRIES];

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // Unsigned 64-bit quotient by shift and subtract, one bit per pass.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = num;
        for (int b = 0; b < 64; b++) begin
            rem = {rem[63:0], quo[63]};
            quo = {quo[62:0], 1'b0};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^-z in Q30 by a series on z/16, then squared four times.
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] z);
        logic [63:0] w;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] r;
        w    = z >> 4;
        sum  = ONE_Q30;
        term = ONE_Q30;
        for (int n = 1; n <= 16; n++) begin
            term = udiv64((term * w) >> 30, 64'(n));
            sum  = sum + term;
        end
        r = udiv64(ONE_Q30 << 30, sum);
        for (int n = 0; n < 4; n++) begin
            r = (r * r) >> 30;
        end
        return r;
    endfunction

    // Builds round(32768 * 0.83 * tanh(1.4 x)) over x in [0, 4].
    function automatic t_clip_rom clip_rom_build();
        t_clip_rom   rom;
        logic [63:0] z;
        logic [63:0] r;
        logic [63:0] q;
        for (int i = 0; i <= CLIP_TABLE_ENTRIES; i++) begin
            z = udiv64(64'(i) * 64'd112 * ONE_Q30, 64'd10 * 64'(CLIP_TABLE_ENTRIES));
            r = exp_neg_q30(z);
            q = udiv64((ONE_Q30 - r) << 30, ONE_Q30 + r);
            rom[i] = 16'((udiv64(q * 64'd83 * 64'd32768, 64'd100) + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

endpackage

FILE: sv/audio_mastering_chain_unit.sv
// ----------------------------------------------------------------------------
// audio_mastering_chain_unit: sample buffer mastering chain.
// Low-pass, soft clip, crush and mix on load; normalize and fade on readout.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one command per transfer: tuser is the function
// (load, emit, restart) and tdata the raw Q3.12 sample for a load. Every
// command but the unused code gives one result transfer on the master stream:
// tdata holds the finished sample and its buffer index, tlast marks the final
// sample, tuser the status. The low-pass gain is written by i_cfg_we.
// A load passes the low-pass, clip, interpolate and mix states to the result
// register; a readout passes the read, multiply and bit-serial divide states,
// the divider scaling each sample by the buffer peak. One command is worked
// on at a time; the next is accepted as soon as the previous result sits in
// the output register. When the receiver stalls, the result holds and a
// further finished result waits in the block until the output register
// frees. The sample store is one single-port RAM. Synchronous reset clears
// the chain state and loads LOWPASS_RESET into the gain register; the store
// keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
module audio_mastering_chain_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // raw_sample
    input  logic [1:0]  i_s_tuser,   // func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // sample_out[15:0], sample_index[33:16], zero
    output logic        o_m_tlast,   // last
    output logic [2:0]  o_m_tuser    // status
);
    import amc_pkg::*;

    localparam t_clip_rom CLIP_ROM = clip_rom_build();

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LP     = 4'd1;
    localparam logic [3:0] S_CLIP   = 4'd2;
    localparam logic [3:0] S_INTERP = 4'd3;
    localparam logic [3:0] S_MIX    = 4'd4;
    localparam logic [3:0] S_RDAT   = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0]               r_state;
    logic [15:0]              r_coeff;
    logic signed [31:0]       r_filt;
    logic signed [15:0]       r_hold;
    logic [15:0]              r_peak;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_ptr;
    logic                     r_reading;

    logic signed [15:0]       r_x;
    logic signed [49:0]       r_prod;
    logic [27:0]              r_frac;
    logic                     r_top;
    logic                     r_neg;
    logic [15:0]              r_rom_lo;
    logic [15:0]              r_rom_hi;
    logic [15:0]              r_interp;
    logic [AM19_W-1:0]        r_am19;
    logic [FN_W-1:0]          r_fnum;
    logic [FN_W-1:0]          r_fden;
    logic [NUM_W-1:0]         r_num;
    logic [DEN_W-1:0]         r_den;
    logic [DEN_W:0]           r_rem;
    logic [DIV_CNT_W-1:0]     r_div_cnt;

    logic [15:0]              r_res_sample;
    logic [17:0]              r_res_index;
    logic                     r_res_last;
    logic [2:0]               r_res_status;

    logic                     r_m_valid;
    logic [15:0]              r_m_sample;
    logic [17:0]              r_m_index;
    logic                     r_m_last;
    logic [2:0]               r_m_status;

    logic signed [15:0]       r_mem_q;
    logic signed [15:0]       sample_store [0:MAX_SAMPLES-1];

    // Combinational values of the load path.
    logic signed [32:0]       lp_diff;
    logic signed [49:0]       lp_sum;
    logic signed [31:0]       lp_new;
    logic [31:0]              lp_abs;
    logic [63:0]              clip_pos;
    logic [63:0]              clip_idx;
    logic                     clip_top;
    logic [ROM_AW-1:0]        rom_addr_lo;
    logic [ROM_AW-1:0]        rom_addr_hi;
    logic [15:0]              rom_diff;
    logic [43:0]              interp_prod;
    logic [15:0]              clip_mag;
    logic signed [16:0]       clip_c;
    logic [16:0]              crush_abs;
    logic [16:0]              crush_mag;
    logic signed [15:0]       hold_now;
    logic signed [18:0]       mix_sum;
    logic signed [15:0]       mix_m;
    logic [15:0]              mix_abs;

    // Combinational values of the readout path.
    logic [15:0]              rd_abs;
    logic [CNT_W-1:0]         rd_tail;
    logic [DEN_W:0]           div_trial;
    logic                     div_bit;
    logic [NUM_W-1:0]         div_num_next;
    logic [15:0]              rd_q;

    logic                     in_xfer;
    logic                     out_free;
    logic                     store_rd;

    assign in_xfer  = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_valid || i_m_tready;
    assign store_rd = in_xfer && (i_s_tuser == FN_EMIT) && (r_ptr < r_count);

    // Low-pass update, clip table addressing.
    always_comb begin
        lp_diff     = 33'(signed'({r_x, 16'd0})) - 33'(r_filt);
        lp_sum      = 50'(r_filt) + (r_prod >>> 16);
        lp_new      = lp_sum[31:0];
        lp_abs      = lp_new[31] ? 32'(-33'(lp_new)) : 32'(lp_new);
        clip_pos    = (64'(lp_abs) * 64'(CLIP_TABLE_ENTRIES)) >> 2;
        clip_idx    = clip_pos >> 28;
        clip_top    = clip_idx >= 64'(CLIP_TABLE_ENTRIES);
        rom_addr_lo = clip_top ? ROM_AW'(CLIP_TABLE_ENTRIES) : clip_idx[ROM_AW-1:0];
        rom_addr_hi = clip_top ? rom_addr_lo : rom_addr_lo + ROM_AW'(1);
    end

    // Interpolation, crush and mix.
    always_comb begin
        rom_diff    = (r_rom_hi > r_rom_lo) ? (r_rom_hi - r_rom_lo) : 16'd0;
        interp_prod = 44'(rom_diff) * 44'(r_frac);
        clip_mag    = r_top ? r_rom_lo : (r_rom_lo + r_interp);
        clip_c      = r_neg ? -17'(clip_mag) : 17'(clip_mag);
        crush_abs   = 17'(clip_mag);
        crush_mag   = ((crush_abs + 17'd256) >> 9) << 9;
        if (r_count[0] == 1'b0) begin
            hold_now = r_neg ? -16'(crush_mag) : 16'(crush_mag);
        end else begin
            hold_now = r_hold;
        end
        mix_sum = 19'(clip_c) * 19'sd3 + 19'(hold_now) + 19'sd2;
        mix_m   = 16'(mix_sum >>> 2);
        mix_abs = mix_m[15] ? 16'(-17'(mix_m)) : 16'(mix_m);
    end

    // Readout scaling and one divider step.
    always_comb begin
        rd_abs       = r_mem_q[15] ? 16'(-17'(r_mem_q)) : 16'(r_mem_q);
        rd_tail      = r_count - CNT_W'(1) - r_ptr;
        div_trial    = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
        div_bit      = div_trial >= {1'b0, r_den};
        div_num_next = {r_num[NUM_W-2:0], div_bit};
        rd_q         = r_neg ? 16'(-17'(div_num_next)) : 16'(div_num_next);
    end

    // Sample store: one port, written on load and read on readout.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MIX) begin
            sample_store[r_count[ADDR_W-1:0]] <= mix_m;
        end
        if (store_rd) begin
            r_mem_q <= sample_store[r_ptr[ADDR_W-1:0]];
        end
    end

    // Clip table, two read ports.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLIP) begin
            r_rom_lo <= CLIP_ROM[rom_addr_lo];
            r_rom_hi <= CLIP_ROM[rom_addr_hi];
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_x <= signed'(i_s_tdata);
            end
            S_LP: begin
                r_prod <= 50'(lp_diff) * 50'(signed'({1'b0, r_coeff}));
            end
            S_CLIP: begin
                r_frac <= clip_pos[27:0];
                r_top  <= clip_top;
                r_neg  <= lp_new[31];
            end
            S_INTERP: begin
                r_interp <= interp_prod[43:28];
            end
            S_RDAT: begin
                r_neg  <= r_mem_q[15];
                r_am19 <= AM19_W'(rd_abs) * AM19_W'(OUT_GAIN);
                if (r_ptr < CNT_W'(FADE_LEN)) begin
                    r_fnum <= FN_W'(r_ptr);
                    r_fden <= FN_W'(FADE_LEN);
                end else if (r_ptr + CNT_W'(FADE_LEN) >= r_count) begin
                    r_fnum <= FN_W'(rd_tail);
                    r_fden <= FN_W'(FADE_LEN);
                end else begin
                    r_fnum <= FN_W'(1);
                    r_fden <= FN_W'(1);
                end
            end
            S_MUL: begin
                r_num     <= NUM_W'(r_am19) * NUM_W'(r_fnum);
                r_den     <= DEN_W'(r_peak) * DEN_W'(r_fden);
                r_rem     <= '0;
            end
            S_DIV: begin
                r_num <= div_num_next;
                r_rem <= div_bit ? (div_trial - {1'b0, r_den}) : div_trial;
            end
            default: begin
            end
        endcase
    end

    // Sequencer and chain state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_coeff   <= LOWPASS_RESET;
            r_filt    <= '0;
            r_hold    <= '0;
            r_peak    <= 16'd1;
            r_count   <= '0;
            r_ptr     <= '0;
            r_reading <= 1'b0;
            r_div_cnt <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_coeff <= i_cfg_wdata;
            end
            if (r_state == S_EMIT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_res_sample <= '0;
                        r_res_index  <= '0;
                        r_res_last   <= 1'b0;
                        unique case (i_s_tuser)
                            FN_LOAD: begin
                                if (r_reading || r_count >= CNT_W'(MAX_SAMPLES)) begin
                                    r_res_status <= ST_DROPPED;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_state <= S_LP;
                                end
                            end
                            FN_EMIT: begin
                                r_reading <= 1'b1;
                                if (r_ptr < r_count) begin
                                    r_state <= S_RDAT;
                                end else begin
                                    r_res_status <= ST_EMPTY;
                                    r_state      <= S_EMIT;
                                end
                            end
                            FN_RESTART: begin
                                r_filt       <= '0;
                                r_hold       <= '0;
                                r_peak       <= 16'd1;
                                r_count      <= '0;
                                r_ptr        <= '0;
                                r_reading    <= 1'b0;
                                r_res_status <= ST_CLEARED;
                                r_state      <= S_EMIT;
                            end
                            FN_UNUSED: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_LP: begin
                    r_state <= S_CLIP;
                end
                S_CLIP: begin
                    r_filt  <= lp_new;
                    r_state <= S_INTERP;
                end
                S_INTERP: begin
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_hold <= hold_now;
                    if (mix_abs > r_peak) begin
                        r_peak <= mix_abs;
                    end
                    r_count      <= r_count + CNT_W'(1);
                    r_res_index  <= 18'(r_count);
                    r_res_status <= ST_LOADED;
                    r_state      <= S_EMIT;
                end
                S_RDAT: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_div_cnt <= '0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                    if (r_div_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                        r_res_sample <= rd_q;
                        r_res_index  <= 18'(r_ptr);
                        r_res_last   <= (r_ptr == r_count - CNT_W'(1));
                        r_res_status <= ST_EMITTED;
                        r_ptr        <= r_ptr + CNT_W'(1);
                        r_state      <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register load.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_m_sample <= r_res_sample;
            r_m_index  <= r_res_index;
            r_m_last   <= r_res_last;
            r_m_status <= r_res_status;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'd0, r_m_index, r_m_sample};
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_status;

endmodule

FILE: dv/audio_mastering_chain_unit_tb.sv
// ----------------------------------------------------------------------------
// audio_mastering_chain_unit_tb: self-checking bench for the mastering chain.
// Streams load, emit, restart and unused commands with random gaps on both
// sides. A scoreboard predicts every result and compares each output transfer
// field by field.
// ----------------------------------------------------------------------------
module audio_mastering_chain_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import amc_pkg::*;

    localparam longint CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        logic [15:0] sample_out;
        logic [17:0] sample_index;
        logic        last;
        logic [2:0]  status;
    } t_chain_result;

    // Predicts the chain and holds the results still owed by the block.
    class chain_scoreboard;
        t_chain_result owed[$];
        int            fails;
        int            checked;
        int unsigned   clip_table[0:CLIP_TABLE_ENTRIES];
        int            coeff;
        int            filt;
        int            hold;
        int            peak;
        int            count;
        int            rptr;
        bit            reading;
        int            store[int];

        function new();
            longint unsigned z;
            longint unsigned r;
            longint unsigned q;
            fails   = 0;
            checked = 0;
            coeff   = 16253;
            clear_chain();
            for (int i = 0; i <= CLIP_TABLE_ENTRIES; i++) begin
                z = (longint'(i) * 112 * (64'd1 << 30)) / (10 * CLIP_TABLE_ENTRIES);
                r = exp_decay(z);
                q = (((64'd1 << 30) - r) << 30) / ((64'd1 << 30) + r);
                clip_table[i] = int'(((q * 83 * 32768) / 100 + (64'd1 << 29)) >> 30);
            end
        endfunction

        // Exponential decay in Q30: series on z/16, squared four times.
        function longint unsigned exp_decay(longint unsigned z);
            longint unsigned w;
            longint unsigned acc;
            longint unsigned term;
            longint unsigned r;
            w    = z >> 4;
            acc  = 64'd1 << 30;
            term = 64'd1 << 30;
            for (int n = 1; n <= 16; n++) begin
                term = ((term * w) >> 30) / n;
                acc  = acc + term;
            end
            r = (64'd1 << 60) / acc;
            for (int n = 0; n < 4; n++) r = (r * r) >> 30;
            return r;
        endfunction

        function void clear_chain();
            filt    = 0;
            hold    = 0;
            peak    = 1;
            count   = 0;
            rptr    = 0;
            reading = 0;
        endfunction

        // Table lookup with linear interpolation, sign restored afterward.
        function int soft_clip(int lp);
            longint unsigned a;
            longint unsigned pos;
            longint unsigned idx;
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned diff;
            int mag;
            a   = (lp < 0) ? longint'(-longint'(lp)) : longint'(lp);
            pos = (a * CLIP_TABLE_ENTRIES) >> 2;
            idx = pos >> 28;
            if (idx >= CLIP_TABLE_ENTRIES) begin
                mag = clip_table[CLIP_TABLE_ENTRIES];
            end else begin
                lo   = clip_table[idx];
                hi   = clip_table[idx + 1];
                diff = (hi > lo) ? hi - lo : 0;
                mag  = int'(lo + ((diff * (pos & ((64'd1 << 28) - 1))) >> 28));
            end
            return (lp < 0) ? -mag : mag;
        endfunction

        // Notes one accepted command and queues the result it causes.
        function void note(logic [1:0] func, logic [15:0] raw);
            t_chain_result res;
            longint lp;
            longint x;
            longint unsigned am64;
            longint unsigned q;
            int c;
            int mag;
            int s;
            int m;
            int fnum;
            int fden;
            res = '0;
            case (func)
                FN_LOAD: begin
                    if (reading || count >= MAX_SAMPLES) begin
                        res.status = ST_DROPPED;
                    end else begin
                        x  = longint'($signed(raw));
                        lp = filt;
                        lp = lp + (((x * 65536 - lp) * longint'(coeff)) >>> 16);
                        filt = int'(lp);
                        c = soft_clip(filt);
                        if (count[0] == 1'b0) begin
                            mag  = (c < 0) ? -c : c;
                            mag  = ((mag + 256) >> 9) << 9;
                            hold = (c < 0) ? -mag : mag;
                        end
                        s = 3 * c + hold + 2 + (1 << 18);
                        m = (s >>> 2) - (1 << 16);
                        store[count] = m;
                        mag = (m < 0) ? -m : m;
                        if (mag > peak) peak = mag;
                        res.sample_index = count[17:0];
                        res.status = ST_LOADED;
                        count++;
                    end
                end
                FN_EMIT: begin
                    reading = 1;
                    if (rptr >= count) begin
                        res.status = ST_EMPTY;
                    end else begin
                        m    = store[rptr];
                        am64 = (m < 0) ? -m : m;
                        if (rptr < FADE_LEN) begin
                            fnum = rptr;
                            fden = FADE_LEN;
                        end else if (rptr >= count - FADE_LEN) begin
                            fnum = count - 1 - rptr;
                            fden = FADE_LEN;
                        end else begin
                            fnum = 1;
                            fden = 1;
                        end
                        q = (am64 * 19200 * fnum) / (longint'(peak) * fden);
                        res.sample_out   = (m < 0) ? 16'(-q) : 16'(q);
                        res.sample_index = rptr[17:0];
                        res.last         = (rptr == count - 1);
                        res.status       = ST_EMITTED;
                        rptr++;
                    end
                end
                FN_RESTART: begin
                    clear_chain();
                    res.status = ST_CLEARED;
                end
                default: return;
            endcase
            owed.push_back(res);
        endfunction

        // Compares one output transfer against the oldest owed result.
        function void check(t_chain_result got);
            t_chain_result exp_res;
            if (owed.size() == 0) begin
                $error("unexpected result transfer: status %0d", got.status);
                fails++;
                return;
            end
            exp_res = owed.pop_front();
            checked++;
            if (got.sample_out !== exp_res.sample_out) begin
                $error("sample_out: expected %0d, actual %0d",
                       $signed(exp_res.sample_out), $signed(got.sample_out));
                fails++;
            end
            if (got.sample_index !== exp_res.sample_index) begin
                $error("sample_index: expected %0d, actual %0d",
                       exp_res.sample_index, got.sample_index);
                fails++;
            end
            if (got.last !== exp_res.last) begin
                $error("last: expected %0d, actual %0d", exp_res.last, got.last);
                fails++;
            end
            if (got.status !== exp_res.status) begin
                $error("status: expected %0d, actual %0d", exp_res.status, got.status);
                fails++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = FN_UNUSED;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic        o_m_tlast;
    logic [2:0]  o_m_tuser;

    chain_scoreboard sb = new();
    longint cycles = 0;
    int     sent = 0;
    int     stall_left = 0;
    bit     gaps_on = 1;

    audio_mastering_chain_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Cycle counter with a hard stop.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: check each transfer and draw random receiver stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check('{o_m_tdata[15:0], o_m_tdata[33:16], o_m_tlast, o_m_tuser});
        end
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (o_m_tvalid && i_m_tready) begin
            stall_left = gaps_on ? $urandom_range(0, 9) : 0;
            i_m_tready <= (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= (stall_left == 0);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // One command transfer; valid stays high into the next one when no gap.
    task automatic send(input logic [1:0] func, input logic [15:0] raw);
        int gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= raw;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note(func, raw);
        sent++;
    endtask

    // Hold off until every owed result has come, then let the block settle.
    task automatic drain();
        @(posedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_coeff(input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.coeff = value;
        @(posedge i_clk);
    endtask

    // One buffer: restart, loads with noise, then readout with stray commands.
    task automatic buffer_run(input int n_load, input int n_extra);
        int pick;
        send(FN_RESTART, 16'($urandom));
        for (int i = 0; i < n_load; i++) begin
            if ($urandom_range(0, 19) == 0) send(FN_UNUSED, 16'($urandom));
            pick = $urandom_range(0, 9);
            if (pick == 0) send(FN_LOAD, 16'h8000);
            else if (pick == 1) send(FN_LOAD, 16'h7FFF);
            else send(FN_LOAD, 16'($urandom));
        end
        for (int i = 0; i < n_load + n_extra; i++) begin
            pick = $urandom_range(0, 39);
            if (pick == 0) send(FN_LOAD, 16'($urandom));
            else if (pick == 1) send(FN_UNUSED, 16'($urandom));
            else if (pick == 2 && n_extra > 0) begin
                send(FN_RESTART, 16'($urandom));
                send(FN_EMIT, 16'($urandom));
                break;
            end
            send(FN_EMIT, 16'($urandom));
        end
    endtask

    initial begin
        logic [15:0] coeff_pick;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty readout, extremes of the sample, load after readout.
        send(FN_EMIT, 16'h0000);
        send(FN_LOAD, 16'h0000);
        send(FN_UNUSED, 16'hFFFF);
        send(FN_RESTART, 16'h0000);
        send(FN_LOAD, 16'h8000);
        send(FN_LOAD, 16'h7FFF);
        send(FN_LOAD, 16'h8000);
        send(FN_LOAD, 16'h0001);
        send(FN_LOAD, 16'hFFFF);
        repeat (6) send(FN_EMIT, 16'h0000);
        send(FN_LOAD, 16'h1234);
        drain();
        write_coeff(16'hFFFF);
        buffer_run(3, 1);
        drain();
        write_coeff(16'h0000);
        buffer_run(2, 1);
        drain();

        // Random buffers over a spread of low-pass gains.
        while (sent < 1200) begin
            case ($urandom_range(0, 4))
                0: coeff_pick = 16'h0000;
                1: coeff_pick = 16'hFFFF;
                2: coeff_pick = LOWPASS_RESET;
                default: coeff_pick = 16'($urandom);
            endcase
            write_coeff(coeff_pick);
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) buffer_run($urandom_range(0, 3), 2);
            else buffer_run($urandom_range(40, 120), $urandom_range(0, 3));
            drain();
        end

        $display("Covered %0d commands and %0d checked results.", sent, sb.checked);
        $display("Gains at both extremes, empty readout, loads after readout and restarts.");
        if (sb.fails == 0 && sb.owed.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

FILE: filelist.f
sv/amc_pkg.sv
sv/audio_mastering_chain_unit.sv
dv/audio_mastering_chain_unit_tb.sv
